@@ hw/rtl/txdq_pkg.sv @@
// Package for the transmit descriptor queue.
// Holds the queue geometry, the request and response payload types and the FSM states.
// No dependencies.
`default_nettype none

package txdq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W      = 32;
	localparam int LEN_W       = 16;
	localparam int TAG_W       = 16;

	typedef enum logic {
		FUNC_ENQUEUE = 1'b0,
		FUNC_DONE    = 1'b1
	} func_t;

	typedef struct packed {
		func_t             func;
		logic [ADDR_W-1:0] buf_addr;
		logic [LEN_W-1:0]  byte_count;
		logic              has_tag;
		logic [TAG_W-1:0]  tag;
	} req_t;

	typedef struct packed {
		logic              accepted;
		logic              start_valid;
		logic [ADDR_W-1:0] start_addr;
		logic [LEN_W-1:0]  start_len;
		logic              notify_valid;
		logic [TAG_W-1:0]  notify_tag;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic load_item;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic rsp_free;
	} sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/txdq_ctrl.sv @@
// Controller FSM of the transmit descriptor queue.
// Sequences request capture and the commit of each transaction; uses txdq_pkg.
`default_nettype none

module txdq_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  wire txdq_pkg::sts_t sts,
	output txdq_pkg::cmd_t     cmd
);

	txdq_pkg::state_t state_q;
	txdq_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= txdq_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			txdq_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_next = txdq_pkg::ST_EXEC;
				end
			end
			txdq_pkg::ST_EXEC: begin
				if (sts.rsp_free) begin
					state_next = txdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = txdq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall     = 1'b1;
		cmd.load_item = 1'b0;
		cmd.commit    = 1'b0;
		case (state_q)
			txdq_pkg::ST_IDLE: begin
				req_stall     = 1'b0;
				cmd.load_item = req_valid;
			end
			txdq_pkg::ST_EXEC: begin
				cmd.commit = sts.rsp_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/txdq_datapath.sv @@
// Datapath of the transmit descriptor queue: request register, descriptor ring
// memories, ring pointers, engine busy flag and response register; uses txdq_pkg.
`default_nettype none

module txdq_datapath (
	input  wire                clk,
	input  wire                arst_n,
	input  wire txdq_pkg::req_t req,
	input  wire txdq_pkg::cmd_t cmd,
	output txdq_pkg::sts_t     sts,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output txdq_pkg::rsp_t     rsp
);

	localparam int TAGE_W = txdq_pkg::TAG_W + 1;

	function automatic logic [txdq_pkg::PTR_W-1:0] next_ptr(
		input logic [txdq_pkg::PTR_W-1:0] p
	);
		logic [txdq_pkg::PTR_W-1:0] n;
		begin
			if (p == txdq_pkg::PTR_W'(txdq_pkg::QUEUE_DEPTH - 1)) begin
				n = '0;
			end else begin
				n = p + 1'b1;
			end
			return n;
		end
	endfunction

	logic [txdq_pkg::ADDR_W-1:0] addr_mem [txdq_pkg::QUEUE_DEPTH];
	logic [txdq_pkg::LEN_W-1:0]  len_mem  [txdq_pkg::QUEUE_DEPTH];
	logic [TAGE_W-1:0]           tag_mem  [txdq_pkg::QUEUE_DEPTH];

	txdq_pkg::req_t              item_q;
	logic [txdq_pkg::ADDR_W-1:0] addr_rd_q;
	logic [txdq_pkg::LEN_W-1:0]  len_rd_q;
	logic [TAGE_W-1:0]           tag_rd_q;
	logic [txdq_pkg::PTR_W-1:0]  wr_q;
	logic [txdq_pkg::PTR_W-1:0]  rd_q;
	logic [txdq_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        rsp_valid_q;
	txdq_pkg::rsp_t              rsp_q;

	logic                        is_enq;
	logic                        is_zero;
	logic                        is_full;
	logic                        do_store;
	logic                        do_pop;
	logic [txdq_pkg::CNT_W-1:0]  cnt_dec;
	txdq_pkg::rsp_t              result;
	logic [txdq_pkg::PTR_W-1:0]  wr_next;
	logic [txdq_pkg::PTR_W-1:0]  rd_next;
	logic [txdq_pkg::CNT_W-1:0]  cnt_next;
	logic                        busy_next;

	assign sts.rsp_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q    <= req;
			tag_rd_q  <= tag_mem[rd_q];
			addr_rd_q <= addr_mem[next_ptr(rd_q)];
			len_rd_q  <= len_mem[next_ptr(rd_q)];
		end
		if (do_store) begin
			addr_mem[wr_q] <= item_q.buf_addr;
			len_mem[wr_q]  <= item_q.byte_count;
			tag_mem[wr_q]  <= {item_q.has_tag, item_q.tag};
		end
	end

	assign is_enq   = (item_q.func == txdq_pkg::FUNC_ENQUEUE);
	assign is_zero  = (item_q.byte_count == '0);
	assign is_full  = (cnt_q == txdq_pkg::CNT_W'(txdq_pkg::QUEUE_DEPTH));
	assign do_store = cmd.commit && is_enq && !is_zero && !is_full;
	assign do_pop   = cmd.commit && !is_enq && (cnt_q != '0);
	assign cnt_dec  = cnt_q - 1'b1;

	always_comb begin
		result    = '0;
		wr_next   = wr_q;
		rd_next   = rd_q;
		cnt_next  = cnt_q;
		busy_next = busy_q;
		if (is_enq) begin
			if (is_zero) begin
				result.accepted     = 1'b1;
				result.notify_valid = item_q.has_tag;
				result.notify_tag   = item_q.has_tag ? item_q.tag : '0;
			end else if (!is_full) begin
				result.accepted = 1'b1;
				wr_next         = next_ptr(wr_q);
				cnt_next        = cnt_q + 1'b1;
				if (cnt_q == '0 && !busy_q) begin
					busy_next          = 1'b1;
					result.start_valid = 1'b1;
					result.start_addr  = item_q.buf_addr;
					result.start_len   = item_q.byte_count;
				end
			end
		end else if (cnt_q != '0) begin
			cnt_next  = cnt_dec;
			rd_next   = next_ptr(rd_q);
			busy_next = 1'b0;
			if (tag_rd_q[TAGE_W-1]) begin
				result.notify_valid = 1'b1;
				result.notify_tag   = tag_rd_q[txdq_pkg::TAG_W-1:0];
			end
			if (cnt_dec != '0) begin
				busy_next          = 1'b1;
				result.start_valid = 1'b1;
				result.start_addr  = addr_rd_q;
				result.start_len   = len_rd_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			cnt_q       <= '0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				wr_q        <= wr_next;
				rd_q        <= rd_next;
				cnt_q       <= cnt_next;
				busy_q      <= busy_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= result;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= txdq_pkg::CNT_W'(txdq_pkg::QUEUE_DEPTH))
		else $error("descriptor count exceeds ring depth");

	a_busy_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("engine busy with an empty ring");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (rd_q == wr_q))
		else $error("empty ring with unequal heads");

	a_commit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid_q)
		else $error("committed transaction produced no response");

	a_pop_store_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_store && do_pop))
		else $error("store and pop in the same transaction");

endmodule

`default_nettype wire

@@ hw/rtl/tx_descriptor_queue.sv @@
// Transmit descriptor queue: a ring of DMA transmit descriptors with completion tags.
// A request is captured with a registered ring memory read, then committed once
// the response register is free, which registers its response. No new request is
// taken until that commit; a stalled response holds the next commit.
// Reset clears the ring heads, entry count, busy flag and response valid;
// descriptor storage is not cleared. Uses txdq_pkg, txdq_ctrl, txdq_datapath.
`default_nettype none

module tx_descriptor_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  wire txdq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output txdq_pkg::rsp_t     rsp
);

	txdq_pkg::cmd_t cmd;
	txdq_pkg::sts_t sts;

	txdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	txdq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for tx_descriptor_queue: directed and random descriptor
// traffic under several idle and stall mixes, checked against an in-bench ring model.
// Depends on txdq_pkg and the tx_descriptor_queue RTL.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	txdq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	txdq_pkg::rsp_t rsp;

	tx_descriptor_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	txdq_pkg::req_t pending_q[$];
	txdq_pkg::rsp_t expected_q[$];
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_go = 1'b0;
	logic hold_rsp = 1'b0;
	int fault_cnt = 0;
	int rsp_cnt = 0;

	logic [txdq_pkg::ADDR_W-1:0] addr_ring[txdq_pkg::QUEUE_DEPTH];
	logic [txdq_pkg::LEN_W-1:0] len_ring[txdq_pkg::QUEUE_DEPTH];
	logic [txdq_pkg::TAG_W:0] tag_ring[txdq_pkg::QUEUE_DEPTH];
	int wr_ptr = 0;
	int rd_ptr = 0;
	int ring_count = 0;
	bit engine_busy = 1'b0;

	function automatic int next_slot(int p);
		return (p == txdq_pkg::QUEUE_DEPTH - 1) ? 0 : p + 1;
	endfunction

	function automatic txdq_pkg::rsp_t ring_step(txdq_pkg::req_t r);
		txdq_pkg::rsp_t o;
		logic [txdq_pkg::TAG_W:0] t;
		o = '0;
		if (r.func == txdq_pkg::FUNC_ENQUEUE) begin
			if (r.byte_count == '0) begin
				o.accepted = 1'b1;
				if (r.has_tag) begin
					o.notify_valid = 1'b1;
					o.notify_tag = r.tag;
				end
			end else if (ring_count < txdq_pkg::QUEUE_DEPTH) begin
				addr_ring[wr_ptr] = r.buf_addr;
				len_ring[wr_ptr] = r.byte_count;
				tag_ring[wr_ptr] = {r.has_tag, r.tag};
				wr_ptr = next_slot(wr_ptr);
				ring_count++;
				o.accepted = 1'b1;
				if (ring_count == 1 && !engine_busy) begin
					engine_busy = 1'b1;
					o.start_valid = 1'b1;
					o.start_addr = r.buf_addr;
					o.start_len = r.byte_count;
				end
			end
		end else if (ring_count != 0) begin
			engine_busy = 1'b0;
			ring_count--;
			t = tag_ring[rd_ptr];
			if (t[txdq_pkg::TAG_W]) begin
				o.notify_valid = 1'b1;
				o.notify_tag = t[txdq_pkg::TAG_W-1:0];
			end
			rd_ptr = next_slot(rd_ptr);
			if (ring_count != 0) begin
				engine_busy = 1'b1;
				o.start_valid = 1'b1;
				o.start_addr = addr_ring[rd_ptr];
				o.start_len = len_ring[rd_ptr];
			end
		end
		return o;
	endfunction

	function automatic txdq_pkg::req_t make_req(txdq_pkg::func_t f,
			logic [txdq_pkg::ADDR_W-1:0] a, logic [txdq_pkg::LEN_W-1:0] n,
			logic ht, logic [txdq_pkg::TAG_W-1:0] tg);
		txdq_pkg::req_t r;
		r.func = f;
		r.buf_addr = a;
		r.byte_count = n;
		r.has_tag = ht;
		r.tag = tg;
		return r;
	endfunction

	function automatic txdq_pkg::req_t random_req(int enq_pct);
		txdq_pkg::req_t r;
		int pick;
		r.func = ($urandom_range(99) < enq_pct) ? txdq_pkg::FUNC_ENQUEUE : txdq_pkg::FUNC_DONE;
		r.buf_addr = $urandom;
		pick = $urandom_range(9);
		if (pick == 0)
			r.byte_count = '0;
		else if (pick == 1)
			r.byte_count = '1;
		else
			r.byte_count = txdq_pkg::LEN_W'($urandom_range(65535, 1));
		r.has_tag = 1'($urandom_range(1));
		r.tag = txdq_pkg::TAG_W'($urandom_range(65535));
		return r;
	endfunction

	// driver: predict on each accepted transaction, then offer the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				expected_q.push_back(ring_step(req));
			if (!req_valid || !req_stall) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					req <= pending_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: drive stall and compare each accepted response with the oldest prediction
	always @(posedge clk) begin : monitor
		txdq_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_cnt++;
			if (expected_q.size() == 0) begin
				if (fault_cnt < 10)
					$display("tb: unexpected response %0d: %p", rsp_cnt, rsp);
				fault_cnt++;
			end else begin
				want = expected_q.pop_front();
				if (rsp.accepted !== want.accepted || rsp.start_valid !== want.start_valid ||
						rsp.start_addr !== want.start_addr ||
						rsp.start_len !== want.start_len ||
						rsp.notify_valid !== want.notify_valid ||
						rsp.notify_tag !== want.notify_tag) begin
					if (fault_cnt < 10)
						$display("tb: mismatch on response %0d: expected %p, got %p",
							rsp_cnt, want, rsp);
					fault_cnt++;
				end
			end
		end
		rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (80) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	initial begin
		#(2_000_000);
		$display("tb: errors");
		$finish;
	end

	task automatic drain_all();
		@(negedge clk);
		while (pending_q.size() > 0 || req_valid || expected_q.size() > 0)
			@(negedge clk);
	endtask

	task automatic queue_random(int count);
		int enq_pct;
		enq_pct = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 16 == 0)
				enq_pct = $urandom_range(1) ? 75 : 30;
			pending_q.push_back(random_req(enq_pct));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		pending_q.push_back(make_req(txdq_pkg::FUNC_DONE, '1, '1, 1'b1, '1));
		pending_q.push_back(make_req(txdq_pkg::FUNC_ENQUEUE, 32'h1234_5678, '0, 1'b1,
			16'hBEEF));
		pending_q.push_back(make_req(txdq_pkg::FUNC_ENQUEUE, '1, '0, 1'b0, '1));
		pending_q.push_back(make_req(txdq_pkg::FUNC_ENQUEUE, '1, '1, 1'b1, '1));
		pending_q.push_back(make_req(txdq_pkg::FUNC_ENQUEUE, '0, 16'd1, 1'b0, '0));
		pending_q.push_back(make_req(txdq_pkg::FUNC_ENQUEUE, 32'h8000_0000, 16'h8000, 1'b1,
			'0));
		for (int i = 0; i < 5; i++)
			pending_q.push_back(make_req(txdq_pkg::FUNC_ENQUEUE, $urandom,
				txdq_pkg::LEN_W'($urandom_range(65535, 1)), i[0],
				txdq_pkg::TAG_W'($urandom_range(65535))));
		pending_q.push_back(make_req(txdq_pkg::FUNC_ENQUEUE, 32'hDEAD_0000, 16'h0040, 1'b1,
			16'h0001));
		pending_q.push_back(make_req(txdq_pkg::FUNC_ENQUEUE, 32'h0000_FFFF, '0, 1'b1,
			16'h7FFF));
		for (int i = 0; i < txdq_pkg::QUEUE_DEPTH; i++)
			pending_q.push_back(make_req(txdq_pkg::FUNC_DONE, '0, '0, 1'b0, '0));
		pending_q.push_back(make_req(txdq_pkg::FUNC_DONE, '0, '0, 1'b0, '0));
		pending_q.push_back(make_req(txdq_pkg::FUNC_ENQUEUE, 32'hA5A5_5A5A, 16'h5A5A, 1'b1,
			16'hA5A5));
		pending_q.push_back(make_req(txdq_pkg::FUNC_DONE, '1, '1, 1'b1, '1));
		drain_all();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 77; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 77; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			queue_random(125);
			drain_all();
		end

		idle_pct = 0;
		stall_pct = 0;
		hold_go = 1'b1;
		queue_random(40);
		drain_all();

		repeat (20) @(posedge clk);
		if (fault_cnt == 0 && expected_q.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/txdq_pkg.sv
hw/rtl/txdq_ctrl.sv
hw/rtl/txdq_datapath.sv
hw/rtl/tx_descriptor_queue.sv
verif/tb.sv
